/* rtl/core/vlc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vlc_pkg
// Shared types, constants and helper functions of the Latin/Cyrillic
// Vigenere cipher block.
// ----------------------------------------------------------------------------
package vlc_pkg;

	// sizing
	localparam int KEY_MAX_DEF = 64;
	localparam int CNT_W       = 9;   // holds key lengths and positions up to 511
	localparam int CHAR_W      = 16;
	localparam int SLOT_W      = 6;
	localparam int KLEN_W      = 7;
	localparam int SHIFT_W     = 5;

	// alphabet sizes
	localparam int LAT_SIZE = 26;
	localparam int CYR_SIZE = 32;

	// letter ranges
	localparam logic [CHAR_W-1:0] LAT_UP_LO = 16'h0041;
	localparam logic [CHAR_W-1:0] LAT_UP_HI = 16'h005A;
	localparam logic [CHAR_W-1:0] LAT_LO_LO = 16'h0061;
	localparam logic [CHAR_W-1:0] LAT_LO_HI = 16'h007A;
	localparam logic [CHAR_W-1:0] CYR_UP_LO = 16'h0410;
	localparam logic [CHAR_W-1:0] CYR_UP_HI = 16'h042F;
	localparam logic [CHAR_W-1:0] CYR_LO_LO = 16'h0430;
	localparam logic [CHAR_W-1:0] CYR_LO_HI = 16'h044F;

	// command codes
	localparam logic CMD_KEY_WRITE = 1'b0;
	localparam logic CMD_CIPHER    = 1'b1;

	// configuration register indexes
	localparam logic CFG_DECRYPT_MODE = 1'b0;
	localparam logic CFG_KEY_LENGTH   = 1'b1;

	// payload of one input transfer
	typedef struct packed {
		logic              command;
		logic [SLOT_W-1:0] key_slot;
		logic [CHAR_W-1:0] char_code;
		logic              first;
	} in_item_t;

	// payload of one output transfer
	typedef struct packed {
		logic [CHAR_W-1:0] char_out;
		logic              key_error;
	} out_item_t;

	// per-slot key shifts, reduced at key write time
	typedef struct packed {
		logic [SHIFT_W-1:0] lat;
		logic [SHIFT_W-1:0] cyr;
	} shift_t;

	// letter classification
	typedef struct packed {
		logic              is_letter;
		logic              is_cyr;
		logic [CHAR_W-1:0] base;
	} letter_t;

	typedef logic [255:0][SHIFT_W-1:0] mod_tab_t;

	// (hi * 256) mod 26 for the upper byte
	function automatic mod_tab_t build_hi_tab();
		mod_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = SHIFT_W'((i * 256) % LAT_SIZE);
		end
		return t;
	endfunction

	// lo mod 26 for the lower byte
	function automatic mod_tab_t build_lo_tab();
		mod_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = SHIFT_W'(i % LAT_SIZE);
		end
		return t;
	endfunction

	localparam mod_tab_t HI_MOD = build_hi_tab();
	localparam mod_tab_t LO_MOD = build_lo_tab();

	// 16-bit value mod 26 from two byte tables and one correction
	function automatic logic [SHIFT_W-1:0] lat_mod(logic [CHAR_W-1:0] c);
		logic [SHIFT_W:0] s;
		s = {1'b0, HI_MOD[c[15:8]]} + {1'b0, LO_MOD[c[7:0]]};
		if (s >= (SHIFT_W+1)'(LAT_SIZE)) begin
			s = s - (SHIFT_W+1)'(LAT_SIZE);
		end
		return s[SHIFT_W-1:0];
	endfunction

	// which case range a code point falls in, if any
	function automatic letter_t letter_class(logic [CHAR_W-1:0] c);
		letter_t r;
		r = '0;
		if (c >= LAT_UP_LO && c <= LAT_UP_HI) begin
			r.is_letter = 1'b1;
			r.base      = LAT_UP_LO;
		end else if (c >= LAT_LO_LO && c <= LAT_LO_HI) begin
			r.is_letter = 1'b1;
			r.base      = LAT_LO_LO;
		end else if (c >= CYR_UP_LO && c <= CYR_UP_HI) begin
			r.is_letter = 1'b1;
			r.is_cyr    = 1'b1;
			r.base      = CYR_UP_LO;
		end else if (c >= CYR_LO_LO && c <= CYR_LO_HI) begin
			r.is_letter = 1'b1;
			r.is_cyr    = 1'b1;
			r.base      = CYR_LO_LO;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/vigenere_latin_cyrillic_cipher_top.sv */
`default_nettype none
// A result passes from the input stage register to the output register.
// Throughput: one item per cycle while the output is not stalled; the key position
// update and the key memory read for the next item complete in the single cipher stage.
// Key writes produce no output and do not wait for the output register.
// Reset clears configuration, letter flags, key position and valid bits at once;
// the key memory itself is not cleared.
// ----------------------------------------------------------------------------
// vigenere_latin_cyrillic_cipher_top
// Vigenere cipher over UTF-16 code points for Latin and Cyrillic letters
// with a key store, an input stage and an output register.
// ----------------------------------------------------------------------------
module vigenere_latin_cyrillic_cipher_top
	import vlc_pkg::*;
#(
	parameter int KEY_MAX = KEY_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_idx,
	input  wire logic [KLEN_W-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire in_item_t          in_item,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output out_item_t              out_item
);

	localparam int POS_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

	logic              decrypt_q;
	logic [KLEN_W-1:0] key_length_q;
	in_item_t          item_s1;
	logic              valid_s1;
	logic [POS_W-1:0]  pos_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic              is_text;
	logic              out_free;
	logic              adv;
	logic              load;
	logic [CNT_W-1:0]  eff_len;
	logic [CNT_W-1:0]  slot_ext;
	logic              slot_ok;
	logic [CNT_W-1:0]  pos_a;
	logic [CNT_W-1:0]  pos_b;
	logic [CNT_W-1:0]  pos_inc;
	logic [CNT_W-1:0]  pos_new;
	logic [POS_W-1:0]  rd_addr;
	shift_t            rd_data;
	shift_t            key0;
	shift_t            key_sel;
	logic              key_ok;
	logic [CHAR_W-1:0] shifted;
	logic              is_letter;
	out_item_t         result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_q    <= 1'b0;
			key_length_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_DECRYPT_MODE: decrypt_q    <= cfg_data[0];
				CFG_KEY_LENGTH:   key_length_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// handshake: stage moves on when it writes a key or the output can take it
	always_comb begin
		is_text  = (item_s1.command == CMD_CIPHER);
		out_free = !out_valid_q || !out_stall;
		adv      = valid_s1 && (!is_text || out_free);
		in_stall = valid_s1 && !adv;
		load     = in_valid && !in_stall;
	end

	// effective key length, saturated at the store depth
	always_comb begin
		if ({{(CNT_W-KLEN_W){1'b0}}, key_length_q} > CNT_W'(KEY_MAX)) begin
			eff_len = CNT_W'(KEY_MAX);
		end else begin
			eff_len = {{(CNT_W-KLEN_W){1'b0}}, key_length_q};
		end
	end

	// key write slot
	always_comb begin
		slot_ext = CNT_W'(item_s1.key_slot);
		slot_ok  = slot_ext < CNT_W'(KEY_MAX);
	end

	// key position: restart, wrap before use, step on letters
	always_comb begin
		pos_a   = item_s1.first ? '0 : CNT_W'(pos_q);
		pos_b   = (pos_a >= eff_len) ? '0 : pos_a;
		pos_inc = pos_b + CNT_W'(1);
		if (!key_ok) begin
			pos_new = pos_a;
		end else if (is_letter) begin
			pos_new = (pos_inc >= eff_len) ? '0 : pos_inc;
		end else begin
			pos_new = pos_b;
		end
		rd_addr = (adv && is_text) ? pos_new[POS_W-1:0] : pos_q;
		key_sel = (pos_b == '0) ? key0 : rd_data;
	end

	vlc_key_store #(
		.KEY_MAX (KEY_MAX),
		.POS_W   (POS_W)
	) u_key_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (adv && !is_text && slot_ok),
		.wr_addr (slot_ext[POS_W-1:0]),
		.wr_char (item_s1.char_code),
		.rd_en   (load),
		.rd_addr (rd_addr),
		.eff_len (eff_len),
		.rd_data (rd_data),
		.key0    (key0),
		.key_ok  (key_ok)
	);

	vlc_shift_unit u_shift_unit (
		.char_in   (item_s1.char_code),
		.shift     (key_sel),
		.decrypt   (decrypt_q),
		.char_out  (shifted),
		.is_letter (is_letter)
	);

	// result of the item in the stage
	always_comb begin
		result.char_out  = key_ok ? shifted : item_s1.char_code;
		result.key_error = !key_ok;
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

	// key position register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (adv && is_text) begin
			pos_q <= pos_new[POS_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && is_text) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_text) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
`default_nettype wire

/* rtl/core/vlc_key_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vlc_key_store
// Key shift memory with registered read and write bypass, a slot zero
// mirror, per-slot letter flags and the key validity check.
// ----------------------------------------------------------------------------
module vlc_key_store
	import vlc_pkg::*;
#(
	parameter int KEY_MAX = KEY_MAX_DEF,
	parameter int POS_W   = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [POS_W-1:0]  wr_addr,
	input  wire logic [CHAR_W-1:0] wr_char,
	input  wire logic              rd_en,
	input  wire logic [POS_W-1:0]  rd_addr,
	input  wire logic [CNT_W-1:0]  eff_len,
	output shift_t                 rd_data,
	output shift_t                 key0,
	output logic                   key_ok
);

	shift_t               mem [KEY_MAX];
	shift_t               rd_q;
	shift_t               key0_q;
	shift_t               wr_shift;
	letter_t              wr_cls;
	logic [KEY_MAX-1:0]   flags_q;
	logic                 wr_letter;
	logic                 bad;

	// reduce the key code point once, at write time
	always_comb begin
		wr_shift.lat = lat_mod(wr_char);
		wr_shift.cyr = wr_char[SHIFT_W-1:0];
		wr_cls       = letter_class(wr_char);
		wr_letter    = wr_cls.is_letter;
	end

	// shift memory, read data registered, write wins on same address
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_shift;
		end
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr) begin
				rd_q <= wr_shift;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	// copy of slot zero for restarts and wraps
	always_ff @(posedge clk) begin
		if (wr_en && wr_addr == '0) begin
			key0_q <= wr_shift;
		end
	end

	// letter flags, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (wr_en) begin
			flags_q[wr_addr] <= wr_letter;
		end
	end

	// every slot below the length must hold a letter, and the length must not be zero
	always_comb begin
		bad = 1'b0;
		for (int i = 0; i < KEY_MAX; i++) begin
			if (!flags_q[i] && CNT_W'(i) < eff_len) begin
				bad = 1'b1;
			end
		end
		key_ok = (eff_len != '0) && !bad;
	end

	assign rd_data = rd_q;
	assign key0    = key0_q;

endmodule
`default_nettype wire

/* rtl/core/vlc_shift_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vlc_shift_unit
// Shifts one code point inside its letter range by the key shift,
// forward for encrypt and backward for decrypt.
// ----------------------------------------------------------------------------
module vlc_shift_unit
	import vlc_pkg::*;
(
	input  wire logic [CHAR_W-1:0] char_in,
	input  wire shift_t            shift,
	input  wire logic              decrypt,
	output logic [CHAR_W-1:0]      char_out,
	output logic                   is_letter
);

	letter_t             cls;
	logic [SHIFT_W-1:0]  off;
	logic [SHIFT_W-1:0]  amt;
	logic [SHIFT_W:0]    sum;
	logic [SHIFT_W-1:0]  res;
	logic [CHAR_W-1:0]   diff;

	// offset inside the case range, shifted with wrap
	always_comb begin
		cls  = letter_class(char_in);
		diff = char_in - cls.base;
		off  = diff[SHIFT_W-1:0];
		amt  = cls.is_cyr ? shift.cyr : shift.lat;
		if (decrypt) begin
			sum = {1'b0, off} - {1'b0, amt};
			if (sum[SHIFT_W] && !cls.is_cyr) begin
				sum = sum + (SHIFT_W+1)'(LAT_SIZE);
			end
		end else begin
			sum = {1'b0, off} + {1'b0, amt};
			if (!cls.is_cyr && sum >= (SHIFT_W+1)'(LAT_SIZE)) begin
				sum = sum - (SHIFT_W+1)'(LAT_SIZE);
			end
		end
		// cyrillic range is 32 wide, so the low bits wrap by themselves
		res       = sum[SHIFT_W-1:0];
		is_letter = cls.is_letter;
		char_out  = cls.is_letter ? (cls.base + CHAR_W'(res)) : char_in;
	end

endmodule
`default_nettype wire

/* sim/vigenere_latin_cyrillic_cipher_top_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vigenere_latin_cyrillic_cipher_top_test
// Self-checking bench for the Latin/Cyrillic Vigenere cipher. A short directed
// run covers the key error cases, range ends and wrap in both directions.
// Random messages follow, mostly a key fill and then a run of text. Idling and
// stalls on both sides are random. Every result is compared with an in-bench
// model of the cipher.
// ---------------------------------------------------------------------------
module vigenere_latin_cyrillic_cipher_top_test
	import vlc_pkg::*;
();

	localparam int HALF_PERIOD   = 5;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int RANDOM_ITEMS  = 1100;
	localparam int IDLE_PCT      = 30;
	localparam int HOLD_CYCLES   = 150;
	localparam int SETTLE_CYCLES = 4;
	localparam int PRINT_MAX     = 40;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              cfg_we   = 1'b0;
	logic              cfg_idx  = CFG_DECRYPT_MODE;
	logic [KLEN_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	in_item_t          in_item  = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_item_t         out_item;

	// cipher model state
	logic [CHAR_W-1:0] key_chars [KEY_MAX_DEF];
	bit                key_is_letter [KEY_MAX_DEF];
	int                key_pos = 0;
	bit                decrypt = 1'b0;
	logic [KLEN_W-1:0] key_len = '0;

	in_item_t  items_to_send [$];
	out_item_t ciphered_due [$];

	bit steady    = 1'b0;
	bit hold_req  = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int failures  = 0;
	int cycles    = 0;

	vigenere_latin_cyrillic_cipher_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	always #HALF_PERIOD clk = ~clk;

	// alphabet size of the code point's case range, zero for a non-letter
	function automatic int letter_size(input int c, output int base);
		base = 0;
		if (c >= LAT_UP_LO && c <= LAT_UP_HI) begin
			base = int'(LAT_UP_LO);
			return LAT_SIZE;
		end
		if (c >= LAT_LO_LO && c <= LAT_LO_HI) begin
			base = int'(LAT_LO_LO);
			return LAT_SIZE;
		end
		if (c >= CYR_UP_LO && c <= CYR_UP_HI) begin
			base = int'(CYR_UP_LO);
			return CYR_SIZE;
		end
		if (c >= CYR_LO_LO && c <= CYR_LO_HI) begin
			base = int'(CYR_LO_LO);
			return CYR_SIZE;
		end
		return 0;
	endfunction

	// key write updates the store; text yields one ciphered character
	task automatic apply_cipher(input in_item_t it);
		int len;
		int base;
		int size;
		int shift;
		int c;
		int r;
		bit usable;
		out_item_t res;
		c = int'(it.char_code);
		if (it.command == CMD_KEY_WRITE) begin
			key_chars[it.key_slot] = it.char_code;
			key_is_letter[it.key_slot] = letter_size(c, base) != 0;
		end else begin
			if (it.first)
				key_pos = 0;
			len = (key_len > KEY_MAX_DEF) ? KEY_MAX_DEF : int'(key_len);
			usable = len != 0;
			for (int i = 0; i < len; i++)
				if (!key_is_letter[i])
					usable = 1'b0;
			r = c;
			if (usable) begin
				if (key_pos >= len)
					key_pos = 0;
				size = letter_size(c, base);
				if (size != 0) begin
					shift = int'(key_chars[key_pos]) % size;
					if (decrypt) begin
						r = c - shift;
						if (r < base)
							r += size;
					end else begin
						r = c + shift;
						if (r > base + size - 1)
							r -= size;
					end
					key_pos++;
					if (key_pos >= len)
						key_pos = 0;
				end
			end
			res.char_out  = r[CHAR_W-1:0];
			res.key_error = !usable;
			ciphered_due.push_back(res);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [CHAR_W-1:0] got,
			input logic [CHAR_W-1:0] want);
		if (failures < PRINT_MAX)
			$display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
		failures++;
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (ciphered_due.size() == 0) begin
			report_mismatch("unexpected result", got.char_out, '0);
		end else begin
			want = ciphered_due.pop_front();
			if (got.char_out !== want.char_out)
				report_mismatch("char_out", got.char_out, want.char_out);
			if (got.key_error !== want.key_error)
				report_mismatch("key_error", CHAR_W'(got.key_error),
					CHAR_W'(want.key_error));
		end
	endtask

	// random code point, letters at the given percentage
	function automatic logic [CHAR_W-1:0] pick_code(input int letter_pct);
		int r;
		r = $urandom_range(99);
		if (r < letter_pct) begin
			case ($urandom_range(3))
				0: return CHAR_W'(LAT_UP_LO + $urandom_range(LAT_SIZE - 1));
				1: return CHAR_W'(LAT_LO_LO + $urandom_range(LAT_SIZE - 1));
				2: return CHAR_W'(CYR_UP_LO + $urandom_range(CYR_SIZE - 1));
				default: return CHAR_W'(CYR_LO_LO + $urandom_range(CYR_SIZE - 1));
			endcase
		end
		// just outside each range, and the excluded io letters
		if (r < letter_pct + 12) begin
			case ($urandom_range(7))
				0: return LAT_UP_LO - CHAR_W'(1);
				1: return LAT_UP_HI + CHAR_W'(1);
				2: return LAT_LO_LO - CHAR_W'(1);
				3: return LAT_LO_HI + CHAR_W'(1);
				4: return CYR_UP_LO - CHAR_W'(1);
				5: return CYR_LO_HI + CHAR_W'(1);
				6: return 16'h0401;
				default: return 16'h0451;
			endcase
		end
		if (r < letter_pct + 24)
			return CHAR_W'($urandom_range(127));
		return CHAR_W'($urandom_range(16'hFFFF));
	endfunction

	task automatic send_key(input int slot, input logic [CHAR_W-1:0] code);
		in_item_t it;
		it = '0;
		it.command   = CMD_KEY_WRITE;
		it.key_slot  = slot[SLOT_W-1:0];
		it.char_code = code;
		items_to_send.push_back(it);
	endtask

	task automatic send_text(input logic [CHAR_W-1:0] code, input bit restart);
		in_item_t it;
		it = '0;
		it.command   = CMD_CIPHER;
		it.key_slot  = SLOT_W'($urandom_range(KEY_MAX_DEF - 1));
		it.char_code = code;
		it.first     = restart;
		items_to_send.push_back(it);
	endtask

	// block idle: nothing queued, nothing offered, nothing outstanding
	task automatic wait_drained();
		do
			@(negedge clk);
		while (items_to_send.size() != 0 || in_valid || ciphered_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_regs(input bit mode, input logic [KLEN_W-1:0] len);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_DECRYPT_MODE;
		cfg_data <= {{(KLEN_W-1){1'b0}}, mode};
		@(posedge clk);
		cfg_idx  <= CFG_KEY_LENGTH;
		cfg_data <= len;
		@(posedge clk);
		cfg_we   <= 1'b0;
		decrypt = mode;
		key_len = len;
		@(negedge clk);
	endtask

	// input driver: a stalled transfer holds, otherwise offer the next item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				apply_cipher(in_item);
			if (!in_valid || !in_stall) begin
				if (items_to_send.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					in_valid <= 1'b1;
					in_item  <= items_to_send.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor: check each transfer, stall at random or for one long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_result(out_item);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int phase_cnt;
		int sent_random;
		int len_w;
		int nkeys;
		int ntext;
		int bad_slot;
		int r;
		in_item_t it;
		phase_cnt   = 0;
		sent_random = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// key length zero after reset: characters pass with the error flag
		send_text(LAT_UP_LO, 1'b1);
		send_text(16'hFFFF, 1'b0);
		wait_drained();
		write_regs(1'b0, 7'd3);

		// slot two never written, then holding a non-letter: key still invalid
		send_key(0, LAT_UP_HI);
		send_key(1, CYR_LO_HI);
		send_text(LAT_LO_LO, 1'b1);
		send_key(2, 16'h0030);
		send_text(LAT_LO_LO + CHAR_W'(1), 1'b0);
		send_key(2, LAT_UP_LO);

		// range ends with wrap, non-letters holding the key position
		send_text(LAT_LO_HI, 1'b1);
		send_text(LAT_UP_LO, 1'b0);
		send_text(CYR_UP_HI, 1'b0);
		send_text(CYR_UP_LO, 1'b0);
		send_text(LAT_UP_LO - CHAR_W'(1), 1'b0);
		send_text(CYR_LO_LO, 1'b0);
		send_text(CYR_LO_HI, 1'b0);
		send_text(16'h0401, 1'b0);
		send_text(LAT_UP_HI + CHAR_W'(1), 1'b0);
		send_text(16'h0000, 1'b0);
		wait_drained();

		// length beyond the key store, upper slots unwritten
		write_regs(1'b1, 7'd127);
		send_text(LAT_LO_HI, 1'b1);
		wait_drained();

		// decrypt wraps below each range start
		write_regs(1'b1, 7'd3);
		send_text(LAT_UP_LO, 1'b1);
		send_text(LAT_LO_LO, 1'b0);
		send_text(CYR_UP_LO, 1'b0);
		send_text(CYR_LO_LO, 1'b0);

		// random messages
		while (sent_random < RANDOM_ITEMS) begin
			wait_drained();
			phase_cnt++;
			steady = (phase_cnt >= 12 && phase_cnt < 18);
			if (phase_cnt == 1 || $urandom_range(3) != 0) begin
				r = $urandom_range(99);
				if (r < 5)
					len_w = 0;
				else if (r < 12)
					len_w = KEY_MAX_DEF;
				else if (r < 16)
					len_w = $urandom_range(127, KEY_MAX_DEF + 1);
				else if (r < 24)
					len_w = $urandom_range(KEY_MAX_DEF - 1, 9);
				else
					len_w = $urandom_range(8, 1);
				write_regs(1'($urandom_range(1)), len_w[KLEN_W-1:0]);
			end
			if (phase_cnt != 5 && $urandom_range(4) == 0) begin
				// noise: any command, slot, code point and first flag
				repeat (20) begin
					it.command   = 1'($urandom_range(1));
					it.key_slot  = SLOT_W'($urandom_range(KEY_MAX_DEF - 1));
					it.char_code = CHAR_W'($urandom_range(16'hFFFF));
					it.first     = 1'($urandom_range(1));
					items_to_send.push_back(it);
				end
				sent_random += 20;
			end else begin
				// well-formed message: fill the key, then a run of text
				nkeys = (key_len > KEY_MAX_DEF) ? KEY_MAX_DEF : int'(key_len);
				bad_slot = (nkeys > 0 && $urandom_range(7) == 0) ? $urandom_range(nkeys - 1) : -1;
				for (int s = 0; s < nkeys; s++)
					send_key(s, (s == bad_slot) ? pick_code(0) : pick_code(100));
				// one long message while the receiver holds off
				if (phase_cnt == 5) begin
					ntext = 300;
					hold_req = 1'b1;
				end else begin
					ntext = $urandom_range(40, 5);
				end
				for (int t = 0; t < ntext; t++)
					send_text(pick_code(65),
						(t == 0 && $urandom_range(9) < 7) || $urandom_range(19) == 0);
				sent_random += nkeys + ntext;
			end
		end

		wait_drained();
		if (failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/vlc_pkg.sv
rtl/core/vlc_key_store.sv
rtl/core/vlc_shift_unit.sv
rtl/core/vigenere_latin_cyrillic_cipher_top.sv
sim/vigenere_latin_cyrillic_cipher_top_test.sv
